/* design/fwhi_pkg.sv */
package fwhi_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int WINDOW    = 16;
	localparam int LANE_W    = 4;
	localparam int LOAD_NUM  = 5;
	localparam int LOAD_DEN  = 4;

	localparam logic [7:0] FP_EMPTY = 8'h00;
	localparam logic [7:0] FP_TOMB  = 8'h01;

	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_ERASE  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_DUP    = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_LANE = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] search_key;
		logic [63:0] key_hash;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  slot_found;
		logic [63:0] found_payload;
		logic        reused_tombstone;
		logic [9:0]  live_entries;
	} rsp_t;

	function automatic logic [7:0] fp_of(input logic [7:0] b);
		return (b[7:1] == 7'd0) ? (b | 8'h02) : b;
	endfunction

	function automatic logic [LANE_W-1:0] low_bit(input logic [WINDOW-1:0] m);
		logic [LANE_W-1:0] r;
		r = '0;
		for (int i = WINDOW - 1; i >= 0; i--) begin
			if (m[i]) r = LANE_W'(i);
		end
		return r;
	endfunction

	function automatic logic [WINDOW-1:0] rot_right(input logic [WINDOW-1:0] m,
			input logic [LANE_W-1:0] s);
		return (m >> s) | (m << (5'd16 - {1'b0, s}));
	endfunction

endpackage

/* design/fwhi_fp_store.sv */
module fwhi_fp_store #(
	parameter int SLOTS = fwhi_pkg::SLOTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [$clog2(SLOTS)-1:0]               rd_at,
	input  logic                                   wr_en,
	input  logic [$clog2(SLOTS)-1:0]               wr_slot,
	input  logic [7:0]                             wr_fp,
	output logic                                   busy,
	output logic [fwhi_pkg::WINDOW-1:0][7:0]       rd_bytes
);
	import fwhi_pkg::*;

	localparam int SW   = $clog2(SLOTS);
	localparam int ROWS = SLOTS / WINDOW;
	localparam int RW   = $clog2(ROWS);

	logic [RW-1:0]     clr_q;
	logic              busy_q;
	logic [LANE_W-1:0] rot_q;
	logic [7:0]        bank_rd [WINDOW];

	// clearing pass: one row of all banks per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == RW'(ROWS - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rot_q <= rd_at[LANE_W-1:0];
	end

	for (genvar b = 0; b < WINDOW; b++) begin : g_bank
		logic [7:0]    mem [ROWS];
		logic [7:0]    rd_q;
		logic [RW-1:0] rrow;
		logic [RW-1:0] wrow;
		logic          we;

		always_comb begin
			rrow = rd_at[SW-1:LANE_W] + RW'(rd_at[LANE_W-1:0] > LANE_W'(b));
			we   = busy_q || (wr_en && (wr_slot[LANE_W-1:0] == LANE_W'(b)));
			wrow = busy_q ? clr_q : wr_slot[SW-1:LANE_W];
		end

		always_ff @(posedge clk) begin
			if (we) mem[wrow] <= busy_q ? FP_EMPTY : wr_fp;
			if (rd_en) rd_q <= mem[rrow];
		end

		assign bank_rd[b] = rd_q;
	end

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			rd_bytes[i] = bank_rd[LANE_W'(rot_q + LANE_W'(i))];
		end
	end

	assign busy = busy_q;

endmodule

/* design/fingerprint_window_hash_index.sv */
// Open-addressing hash index with per-slot fingerprint bytes.
// Request channel: in_valid / in_stall / in_data (operation, key, hash, payload).
// Response channel: out_valid / out_stall / out_data, one beat per request.
// Config port: cfg_we/cfg_index/cfg_data, write only; user writes only while idle.
// One request is in flight at a time; in_stall is high until its beat is
// loaded into the output register. A response waiting under out_stall does
// not block the next request from being taken.
// Accept to beat: an answer state, then per fingerprint window probed a read,
// a compare and a lane scan, and per candidate whose key is checked a lane
// pick, a slot entry read and a key check; the lane scan of the window holding
// a hit is not spent. A miss adds a miss state, an insert a read and a compare
// per window searched for a free lane and then a write. A successful erase that
// moves a dense entry adds a move read, a move write and a second probe for it.
// Throughput: the next request is taken the cycle after the beat is loaded.
// The loop is set by the single window read port of the fingerprint banks and
// the single read port of the slot and dense entry memories.
// Config writes are not gated by the block. After reset the fingerprint banks
// are cleared row by row, in_stall held high; config writes are taken meanwhile.
module fingerprint_window_hash_index #(
	parameter int SLOTS = fwhi_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fwhi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fwhi_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fwhi_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fwhi_pkg::rsp_t                      out_data
);
	import fwhi_pkg::*;

	localparam int SW          = $clog2(SLOTS);
	localparam int PROBE_LIMIT = (SLOTS - 1) / WINDOW + 3;
	localparam int DW          = $clog2(PROBE_LIMIT + 1);
	localparam int CW          = SW + 3;
	localparam logic [CW-1:0] FULL_AT = CW'(SLOTS * LOAD_DEN);

	localparam logic [1:0] P_FIND = 2'd0;
	localparam logic [1:0] P_FREE = 2'd1;
	localparam logic [1:0] P_REPT = 2'd2;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_WIN_RD   = 4'd1;
	localparam logic [3:0] S_WIN_EVAL = 4'd2;
	localparam logic [3:0] S_CAND     = 4'd3;
	localparam logic [3:0] S_SE_WAIT  = 4'd4;
	localparam logic [3:0] S_KEY_CHK  = 4'd5;
	localparam logic [3:0] S_MISS     = 4'd6;
	localparam logic [3:0] S_MOVE_RD  = 4'd7;
	localparam logic [3:0] S_MOVE_WR  = 4'd8;
	localparam logic [3:0] S_INS_WR   = 4'd9;
	localparam logic [3:0] S_RESP     = 4'd10;

	function automatic logic [SW-1:0] home_of(input logic [63:0] h, input logic lay);
		return lay ? h[63 -: SW] : {h[63 -: SW-LANE_W], LANE_W'(0)};
	endfunction

	logic [3:0]        state_q;
	logic [1:0]        purp_q;
	req_t              req_q;
	logic              layout_q;
	logic              rotate_q;
	logic [SW-1:0]     at_q;
	logic [DW-1:0]     delta_q;
	logic [7:0]        pfp_q;
	logic [WINDOW-1:0] lanes_q;
	logic              empty_q;
	logic [SW-1:0]     cand_q;
	logic [SW-1:0]     se_rd_q;
	logic [63:0]       key_rd_q;
	logic [63:0]       val_rd_q;
	logic [63:0]       hash_rd_q;
	logic [SW-1:0]     count_q;
	logic [SW-1:0]     occ_q;
	logic [SW-1:0]     gone_q;
	logic [SW-1:0]     last_q;
	logic [SW-1:0]     free_q;
	logic              reused_q;
	logic [1:0]        st_q;
	logic [SW-1:0]     slot_q;
	logic [63:0]       pay_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [SW-1:0] slot_entry [SLOTS];
	logic [63:0]   ent_key    [SLOTS];
	logic [63:0]   ent_val    [SLOTS];
	logic [63:0]   ent_hash   [SLOTS];

	logic                    fs_busy;
	logic                    fs_rd_en;
	logic                    fs_wr_en;
	logic [SW-1:0]           fs_wr_slot;
	logic [7:0]              fs_wr_fp;
	logic [WINDOW-1:0][7:0]  win;

	logic [WINDOW-1:0] match;
	logic [WINDOW-1:0] emp;
	logic [WINDOW-1:0] avail;
	logic [LANE_W-1:0] free_lane;
	logic [SW-1:0]     cand_slot;
	logic [SW-1:0]     next_at;
	logic              at_limit;
	logic [3:0]        adv_state;
	logic              full_chk;
	logic              hit;
	logic [SW-1:0]     last_idx;

	logic          se_we;
	logic [SW-1:0] se_wa;
	logic [SW-1:0] se_wd;
	logic          ent_we;
	logic          ent_re;
	logic [SW-1:0] ent_wa;
	logic [SW-1:0] ent_ra;

	fwhi_fp_store #(.SLOTS(SLOTS)) u_fp (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (fs_rd_en),
		.rd_at    (at_q),
		.wr_en    (fs_wr_en),
		.wr_slot  (fs_wr_slot),
		.wr_fp    (fs_wr_fp),
		.busy     (fs_busy),
		.rd_bytes (win)
	);

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			match[i] = (win[i] == pfp_q);
			emp[i]   = (win[i] == FP_EMPTY);
			avail[i] = (win[i] == FP_EMPTY) || (win[i] == FP_TOMB);
		end
		if (rotate_q) begin
			free_lane = LANE_W'(low_bit(rot_right(avail, req_q.key_hash[11:8]))
				+ req_q.key_hash[11:8]);
		end else begin
			free_lane = low_bit(avail);
		end
		cand_slot = at_q + SW'(low_bit(lanes_q));
		next_at   = at_q + SW'({delta_q, LANE_W'(0)});
		at_limit  = (delta_q == DW'(PROBE_LIMIT));
		if (at_limit) adv_state = (purp_q == P_FIND) ? S_MISS : S_RESP;
		else adv_state = S_WIN_RD;
		full_chk = ((CW'(occ_q) + CW'(1)) * CW'(LOAD_NUM)) >= FULL_AT;
		hit      = (key_rd_q == req_q.search_key);
		last_idx = count_q - 1'b1;

		fs_rd_en   = (state_q == S_WIN_RD);
		fs_wr_en   = (state_q == S_INS_WR) ||
			((state_q == S_KEY_CHK) && hit && (req_q.operation == OP_ERASE));
		fs_wr_slot = (state_q == S_INS_WR) ? free_q : cand_q;
		fs_wr_fp   = (state_q == S_INS_WR) ? fp_of(req_q.key_hash[7:0]) : FP_TOMB;

		se_we = (state_q == S_INS_WR) ||
			((state_q == S_SE_WAIT) && (purp_q == P_REPT) && (se_rd_q == last_q));
		se_wa = (state_q == S_INS_WR) ? free_q : cand_q;
		se_wd = (state_q == S_INS_WR) ? count_q : gone_q;

		ent_we = (state_q == S_INS_WR) || (state_q == S_MOVE_WR);
		ent_wa = (state_q == S_INS_WR) ? count_q : gone_q;
		ent_re = ((state_q == S_SE_WAIT) && (purp_q != P_REPT)) || (state_q == S_MOVE_RD);
		ent_ra = (state_q == S_MOVE_RD) ? last_q : se_rd_q;
	end

	always_ff @(posedge clk) begin
		if (se_we) slot_entry[se_wa] <= se_wd;
		if (state_q == S_CAND) se_rd_q <= slot_entry[cand_slot];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_key[ent_wa]  <= (state_q == S_INS_WR) ? req_q.search_key : key_rd_q;
			ent_val[ent_wa]  <= (state_q == S_INS_WR) ? req_q.payload : val_rd_q;
			ent_hash[ent_wa] <= (state_q == S_INS_WR) ? req_q.key_hash : hash_rd_q;
		end
		if (ent_re) begin
			key_rd_q  <= ent_key[ent_ra];
			val_rd_q  <= ent_val[ent_ra];
			hash_rd_q <= ent_hash[ent_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b1;
			rotate_q <= 1'b0;
		end else if (cfg_we) begin
			priority if (cfg_index == REG_LAYOUT_MODE) layout_q <= cfg_data[0];
			else if (cfg_index == REG_ROTATE_LANE) rotate_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			purp_q      <= P_FIND;
			count_q     <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_RESP) && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q    <= in_data;
						purp_q   <= P_FIND;
						at_q     <= home_of(in_data.key_hash, layout_q);
						delta_q  <= DW'(1);
						pfp_q    <= fp_of(in_data.key_hash[7:0]);
						reused_q <= 1'b0;
						pay_q    <= '0;
						slot_q   <= '0;
						st_q     <= ST_ABSENT;
						if (in_data.operation != OP_FIND && in_data.operation != OP_INSERT &&
								in_data.operation != OP_ERASE) begin
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							state_q <= S_MISS;
						end else begin
							state_q <= S_WIN_RD;
						end
					end
				end
				S_WIN_RD: state_q <= S_WIN_EVAL;
				S_WIN_EVAL: begin
					if (purp_q == P_FREE) begin
						if (avail != '0) begin
							free_q   <= at_q + SW'(free_lane);
							reused_q <= !emp[free_lane];
							state_q  <= S_INS_WR;
						end else begin
							state_q <= adv_state;
							at_q    <= next_at;
							delta_q <= delta_q + 1'b1;
							if (at_limit) st_q <= ST_FULL;
						end
					end else begin
						lanes_q <= match;
						empty_q <= |emp;
						state_q <= S_CAND;
					end
				end
				S_CAND: begin
					if (lanes_q == '0) begin
						if ((purp_q == P_FIND) && empty_q) begin
							state_q <= S_MISS;
						end else begin
							state_q <= adv_state;
							at_q    <= next_at;
							delta_q <= delta_q + 1'b1;
						end
					end else begin
						cand_q  <= cand_slot;
						lanes_q <= lanes_q & (lanes_q - 1'b1);
						state_q <= S_SE_WAIT;
					end
				end
				S_SE_WAIT: begin
					if (purp_q == P_REPT) state_q <= (se_rd_q == last_q) ? S_RESP : S_CAND;
					else state_q <= S_KEY_CHK;
				end
				S_KEY_CHK: begin
					if (hit) begin
						slot_q <= cand_q;
						unique case (req_q.operation)
							OP_FIND: begin
								st_q    <= ST_OK;
								pay_q   <= val_rd_q;
								state_q <= S_RESP;
							end
							OP_INSERT: begin
								st_q    <= ST_DUP;
								state_q <= S_RESP;
							end
							default: begin
								st_q    <= ST_OK;
								gone_q  <= se_rd_q;
								last_q  <= last_idx;
								count_q <= last_idx;
								state_q <= (se_rd_q != last_idx) ? S_MOVE_RD : S_RESP;
							end
						endcase
					end else begin
						state_q <= S_CAND;
					end
				end
				S_MISS: begin
					if (req_q.operation == OP_INSERT) begin
						if (full_chk) begin
							st_q    <= ST_FULL;
							state_q <= S_RESP;
						end else begin
							purp_q  <= P_FREE;
							at_q    <= home_of(req_q.key_hash, layout_q);
							delta_q <= DW'(1);
							state_q <= S_WIN_RD;
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: begin
					purp_q  <= P_REPT;
					at_q    <= home_of(hash_rd_q, layout_q);
					pfp_q   <= fp_of(hash_rd_q[7:0]);
					delta_q <= DW'(1);
					state_q <= S_WIN_RD;
				end
				S_INS_WR: begin
					count_q <= count_q + 1'b1;
					if (!reused_q) occ_q <= occ_q + 1'b1;
					st_q    <= ST_OK;
					slot_q  <= free_q;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_q.status           <= st_q;
						out_q.slot_found       <= 10'(slot_q);
						out_q.found_payload    <= pay_q;
						out_q.reused_tombstone <= reused_q;
						out_q.live_entries     <= 10'(count_q);
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE) || fs_busy;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_live_le_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= occ_q)
		else $error("live entries exceed occupied slots");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		fs_busy |-> in_stall)
		else $error("request taken during fingerprint clear");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not bump live count");

	a_beat_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("response beat without response state");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

class hash_index_board;
	fwhi_pkg::rsp_t answers[$];
	int errors;
	int checked;
	int insert_cnt, find_hit_cnt, erase_cnt, full_cnt;

	bit mode_sliding;
	bit rotate_lane;
	logic [7:0]  fp_mem[0:1039];
	logic [9:0]  slot_ent[0:1023];
	logic [63:0] ent_key[0:1023];
	logic [63:0] ent_val[0:1023];
	logic [63:0] ent_hash[0:1023];
	int live_cnt;
	int used_slots;

	function void clear();
		mode_sliding = 1;
		rotate_lane = 0;
		for (int i = 0; i < 1040; i++) fp_mem[i] = fwhi_pkg::FP_EMPTY;
		for (int i = 0; i < 1024; i++) begin
			slot_ent[i] = '0;
			ent_key[i] = '0;
			ent_val[i] = '0;
			ent_hash[i] = '0;
		end
		live_cnt = 0;
		used_slots = 0;
		errors = 0;
		checked = 0;
	endfunction

	function int home_slot(logic [63:0] h);
		if (!mode_sliding) return int'(h[63:58]) * 16;
		return int'(h[63:54]);
	endfunction

	function logic [7:0] tag_of(logic [63:0] h);
		if (h[7:1] == 7'd0) return h[7:0] + 8'd2;
		return h[7:0];
	endfunction

	function void put_tag(int s, logic [7:0] v);
		s = s & 1023;
		fp_mem[s] = v;
		if (s < 16) fp_mem[1024 + s] = v;
	endfunction

	function logic [15:0] lanes_eq(int at, logic [7:0] v);
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < 16; i++)
			if (fp_mem[(at & 1023) + i] == v) m[i] = 1'b1;
		return m;
	endfunction

	function int first_lane(logic [15:0] m);
		for (int i = 0; i < 16; i++) if (m[i]) return i;
		return 31;
	endfunction

	function bit lookup(logic [63:0] k, logic [63:0] h, output int slot);
		logic [7:0] t;
		logic [15:0] m;
		int at, s;
		t = tag_of(h);
		at = home_slot(h);
		slot = 0;
		if (live_cnt == 0) return 0;
		for (int d = 1; d <= 66; d++) begin
			m = lanes_eq(at, t);
			while (m != 0) begin
				s = (at + first_lane(m)) & 1023;
				if (ent_key[slot_ent[s]] == k) begin
					slot = s;
					return 1;
				end
				m = m & (m - 16'd1);
			end
			if (lanes_eq(at, fwhi_pkg::FP_EMPTY) != 0) return 0;
			at = (at + d * 16) & 1023;
		end
		return 0;
	endfunction

	function bit pick_free(logic [63:0] h, output int slot);
		logic [15:0] av, r;
		int at, st, ln;
		at = home_slot(h);
		slot = 0;
		for (int d = 1; d <= 66; d++) begin
			av = lanes_eq(at, fwhi_pkg::FP_EMPTY) | lanes_eq(at, fwhi_pkg::FP_TOMB);
			if (av != 0) begin
				if (rotate_lane) begin
					st = int'(h[11:8]);
					r = (av >> st) | (av << (16 - st));
					ln = (first_lane(r) + st) & 15;
				end else ln = first_lane(av);
				slot = (at + ln) & 1023;
				return 1;
			end
			at = (at + d * 16) & 1023;
		end
		return 0;
	endfunction

	function void relink(int from, int to);
		logic [63:0] h;
		logic [15:0] m;
		int at, s;
		h = ent_hash[to];
		at = home_slot(h);
		for (int d = 1; d <= 66; d++) begin
			m = lanes_eq(at, tag_of(h));
			while (m != 0) begin
				s = (at + first_lane(m)) & 1023;
				if (slot_ent[s] == from) begin
					slot_ent[s] = 10'(to);
					return;
				end
				m = m & (m - 16'd1);
			end
			at = (at + d * 16) & 1023;
		end
	endfunction

	function void note_request(fwhi_pkg::req_t q);
		fwhi_pkg::rsp_t a;
		int s, e, gone, last;
		a = '0;
		a.status = fwhi_pkg::ST_ABSENT;
		if (q.operation == fwhi_pkg::OP_FIND) begin
			if (lookup(q.search_key, q.key_hash, s)) begin
				a.status = fwhi_pkg::ST_OK;
				a.slot_found = 10'(s);
				a.found_payload = ent_val[slot_ent[s]];
				find_hit_cnt++;
			end
		end else if (q.operation == fwhi_pkg::OP_INSERT) begin
			if (lookup(q.search_key, q.key_hash, s)) begin
				a.status = fwhi_pkg::ST_DUP;
				a.slot_found = 10'(s);
			end else if ((used_slots + 1) * 5 >= 4096 || !pick_free(q.key_hash, s)) begin
				a.status = fwhi_pkg::ST_FULL;
				full_cnt++;
			end else begin
				e = live_cnt & 1023;
				ent_key[e] = q.search_key;
				ent_val[e] = q.payload;
				ent_hash[e] = q.key_hash;
				live_cnt++;
				if (fp_mem[s] == fwhi_pkg::FP_EMPTY) used_slots++;
				else a.reused_tombstone = 1'b1;
				put_tag(s, tag_of(q.key_hash));
				slot_ent[s] = 10'(e);
				a.status = fwhi_pkg::ST_OK;
				a.slot_found = 10'(s);
				insert_cnt++;
			end
		end else if (q.operation == fwhi_pkg::OP_ERASE) begin
			if (lookup(q.search_key, q.key_hash, s)) begin
				gone = int'(slot_ent[s]);
				last = (live_cnt - 1) & 1023;
				put_tag(s, fwhi_pkg::FP_TOMB);
				if (gone != last) begin
					ent_key[gone] = ent_key[last];
					ent_val[gone] = ent_val[last];
					ent_hash[gone] = ent_hash[last];
					relink(last, gone);
				end
				live_cnt--;
				a.status = fwhi_pkg::ST_OK;
				a.slot_found = 10'(s);
				erase_cnt++;
			end
		end
		a.live_entries = 10'(live_cnt);
		answers = {answers, a};
	endfunction

	function void check_response(fwhi_pkg::rsp_t got);
		fwhi_pkg::rsp_t w;
		checked++;
		if (answers.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected beat %h", got);
			return;
		end
		w = answers.pop_front();
		if (got.status !== w.status || got.slot_found !== w.slot_found ||
				got.found_payload !== w.found_payload ||
				got.reused_tombstone !== w.reused_tombstone ||
				got.live_entries !== w.live_entries) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch #%0d: exp st=%0d slot=%0d val=%h tomb=%0b live=%0d",
					checked, w.status, w.slot_found, w.found_payload, w.reused_tombstone,
					w.live_entries);
				$display("    got st=%0d slot=%0d val=%h tomb=%0b live=%0d",
					got.status, got.slot_found, got.found_payload,
					got.reused_tombstone, got.live_entries);
			end
		end
	endfunction
endclass

module tb;
	import fwhi_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	rsp_t out_data;

	hash_index_board board;
	bit quiet;
	logic [63:0] key_pool[$];
	logic [63:0] hash_pool[$];

	always #2 clk = ~clk;

	fingerprint_window_hash_index DUT (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_response(out_data);
	end

	initial begin : rx_idle
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_LAYOUT_MODE) board.mode_sliding = v;
		else board.rotate_lane = v;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.answers.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic send(logic [1:0] op, logic [63:0] k, logic [63:0] h, logic [63:0] v);
		req_t q;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		q.operation = op;
		q.search_key = k;
		q.key_hash = h;
		q.payload = v;
		in_valid <= 1;
		in_data <= q;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(q);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(int n, bit crowd);
		logic [63:0] k, h;
		int r, p;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (key_pool.size() == 0 || r < 40) begin
				k = rnd64();
				h = rnd64();
				if (crowd) h[63:54] = 10'($urandom_range(0, 40));
				if ($urandom_range(0, 3) == 0) h[7:0] = 8'($urandom_range(0, 3));
				key_pool = {key_pool, k};
				hash_pool = {hash_pool, h};
				send(OP_INSERT, k, h, rnd64());
			end else if (r < 95) begin
				p = $urandom_range(0, key_pool.size() - 1);
				send(($urandom_range(0, 2) == 0) ? OP_ERASE :
					(($urandom_range(0, 3) == 0) ? OP_INSERT : OP_FIND),
					key_pool[p], hash_pool[p], rnd64());
			end else begin
				send((r == 99) ? OP_UNUSED : OP_FIND, rnd64(), rnd64(), rnd64());
			end
		end
	endtask

	initial begin
		#10000000;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [63:0] h;
		board = new();
		board.clear();
		quiet = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(OP_FIND, 64'h0, 64'h0, 64'h0);
		send(OP_ERASE, '1, '1, '1);
		send(OP_INSERT, 64'h0, 64'h0, '1);
		send(OP_INSERT, '1, '1, 64'h0);
		send(OP_INSERT, 64'h5, 64'h0000_0000_0000_0001, 64'h55);
		send(OP_INSERT, 64'h6, 64'hFFC0_0000_0000_0F00, 64'h66);
		send(OP_INSERT, 64'h0, 64'h0, 64'h1);
		send(OP_FIND, '1, '1, 64'h0);
		send(OP_FIND, 64'h7, 64'h0, 64'h0);
		send(OP_UNUSED, 64'h5, 64'h1, 64'h0);
		send(OP_ERASE, 64'h0, 64'h0, 64'h0);
		send(OP_INSERT, 64'h8, 64'h0, 64'h88);
		send(OP_FIND, 64'h5, 64'h1, 64'h0);
		send(OP_ERASE, 64'h5, 64'h1, 64'h0);
		send(OP_FIND, 64'h8, 64'h0, 64'h0);
		drain();
		write_reg(REG_ROTATE_LANE, 1);
		for (int i = 0; i < 5; i++) begin
			h = rnd64();
			h[63:54] = 10'h3FA;
			send(OP_INSERT, 64'h100 + i, h, rnd64());
		end
		send(OP_FIND, 64'h6, 64'hFFC0_0000_0000_0F00, 64'h0);
		drain();
		write_reg(REG_LAYOUT_MODE, 0);
		send(OP_FIND, 64'h8, 64'h0, 64'h0);
		send(OP_FIND, '1, '1, 64'h0);

		random_phase(120, 0);
		drain();
		write_reg(REG_ROTATE_LANE, 0);
		random_phase(100, 1);
		drain();
		write_reg(REG_LAYOUT_MODE, 1);
		write_reg(REG_ROTATE_LANE, 1);
		random_phase(130, 1);
		quiet = 1;
		random_phase(100, 0);

		in_valid <= 0;
		while (board.answers.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d beats: %0d inserts, %0d find hits, %0d erases, %0d full",
			board.checked, board.insert_cnt, board.find_hit_cnt, board.erase_cnt,
			board.full_cnt);
		$display("both layouts and lane rotation settings exercised, %0d live at end",
			board.live_cnt);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

/* sim.f */
design/fwhi_pkg.sv
design/fwhi_fp_store.sv
design/fingerprint_window_hash_index.sv
tb/sv/tb.sv
